// ===== hdl/clfb_pkg.sv =====
// clfb_pkg: shared types, codes and the display character map for the
// character LCD frame buffer. No dependencies.
package clfb_pkg;

   localparam int CHAR_W   = 8;
   localparam int CURSOR_W = 7;

   localparam logic [CHAR_W-1:0] SPACE_C = 8'h20;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_PAIR  = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic {
      CSR_ENABLE   = 1'b0,
      CSR_LINE_LEN = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   localparam logic [7:0] PAIR_DATA = 8'h03;
   localparam logic [7:0] PAIR_CMD  = 8'h02;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_ENTRY = 8'h06;
   localparam logic [7:0] CMD_HOME  = 8'h02;
   localparam logic [7:0] CMD_ADDR0 = 8'h80;

   // Map a stored code to what the display can show.
   function automatic logic [CHAR_W-1:0] char_map(input logic [CHAR_W-1:0] v);
      logic [CHAR_W-1:0] r;
      case (v)
         8'hc4, 8'hd6, 8'hdc, 8'hdf, 8'he4, 8'hf6, 8'hfc: r = v;
         8'd11:                       r = 8'h23; // '#'
         8'd16:                       r = 8'h3e; // '>'
         8'd22:                       r = 8'h40; // '@'
         8'd145:                      r = SPACE_C;
         8'd152:                      r = 8'h6f; // 'o'
         8'd224, 8'd226:              r = 8'h61; // 'a'
         8'd231:                      r = 8'h63; // 'c'
         8'd232, 8'd233, 8'd234, 8'd235: r = 8'h65; // 'e'
         8'd238, 8'd239:              r = 8'h69; // 'i'
         8'd244:                      r = 8'h6f; // 'o'
         8'd249, 8'd251:              r = 8'h75; // 'u'
         8'd255:                      r = 8'h79; // 'y'
         default: r = (v >= 8'h20 && v <= 8'h7e) ? v : SPACE_C;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/clfb_store.sv =====
// clfb_store: character store with registered read and per-entry valid bits,
// so that a clear resets only the valid bits. Depends on clfb_pkg.
module clfb_store #(
   parameter int DEPTH = 80
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [clfb_pkg::CHAR_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [clfb_pkg::CHAR_W-1:0] rd_data
);

   logic [clfb_pkg::CHAR_W-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [clfb_pkg::CHAR_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= store_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Entries never written since the last clear or reset read as space.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : clfb_pkg::SPACE_C;

endmodule

// ===== hdl/char_lcd_frame_buffer.sv =====
// char_lcd_frame_buffer: two-line character display memory driven by
// command/data pairs. Depends on clfb_pkg and clfb_store.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   req     | in        | req_valid/req_ready, opcode, pair_type/value, cell_index
//   rsp     | out       | rsp_valid/rsp_ready, cell_char, cursor_pos, in_range
//   csr     | in        | csr_we, csr_index, csr_wdata (write only, no wait)
//
// Start, pair and out-of-range read words load the result register directly;
// an in-range read first passes through ST_READ, as the store read is registered.
// Reset clears control state and all store valid bits, so the
// store reads as spaces at once; enable resets to 0, line length to 20.
// A stalled result holds in the output register and blocks new words.
module char_lcd_frame_buffer #(
   parameter int MAX_LINE = 40
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_pair_type,
   input  logic [7:0]  req_pair_value,
   input  logic [6:0]  req_cell_index,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_char,
   output logic [6:0]  rsp_cursor_pos,
   output logic        rsp_in_range,

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int DEPTH = 2 * MAX_LINE;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [clfb_pkg::CURSOR_W-1:0] MAX_LEN_C =
      clfb_pkg::CURSOR_W'(MAX_LINE);

   // Configuration
   logic       enable_ff;
   logic [5:0] line_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         line_len_ff <= 6'd20;
      end else if (csr_we) begin
         case (clfb_pkg::csr_index_type'(csr_index))
            clfb_pkg::CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            clfb_pkg::CSR_LINE_LEN: line_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective line length, saturated to 1..MAX_LINE; two lines never
   // exceed 126 cells, so seven bits hold every cursor value.
   logic [clfb_pkg::CURSOR_W-1:0] len_ext, eff_len, size;

   always_comb begin
      len_ext = {1'b0, line_len_ff};
      if (len_ext == '0) begin
         eff_len = clfb_pkg::CURSOR_W'(1);
      end else if (len_ext > MAX_LEN_C) begin
         eff_len = MAX_LEN_C;
      end else begin
         eff_len = len_ext;
      end
      size = eff_len << 1;
   end

   // Address command target: line two begins at 0x40, clamp at the end.
   logic [clfb_pkg::CURSOR_W-1:0] addr_raw, addr_tgt;

   always_comb begin
      if (req_pair_value[6]) begin
         addr_raw = eff_len + {1'b0, req_pair_value[5:0]};
      end else begin
         addr_raw = {1'b0, req_pair_value[5:0]};
      end
      addr_tgt = (addr_raw < size) ? addr_raw : size;
   end

   // Control and result registers
   clfb_pkg::state_type           state_ff, state_in;
   logic [clfb_pkg::CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clfb_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [clfb_pkg::CURSOR_W-1:0] rsp_cursor_ff;
   logic                          rsp_range_ff, rsp_range_in;
   logic                          load_rsp;

   logic                          accept;
   logic                          st_clear, st_wr_en, st_rd_en;
   logic [clfb_pkg::CHAR_W-1:0]   st_rd_data;

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      st_clear     = 1'b0;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;
      load_rsp     = 1'b0;
      rsp_char_in  = '0;
      rsp_range_in = 1'b0;
      req_ready    = 1'b0;
      accept       = 1'b0;
      // Drop the held result once it is taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         clfb_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               case (clfb_pkg::opcode_type'(req_opcode))
                  clfb_pkg::OP_START: begin
                     load_rsp = 1'b1;
                     if (enable_ff) begin
                        st_clear  = 1'b1;
                        cursor_in = '0;
                     end
                  end
                  clfb_pkg::OP_PAIR: begin
                     load_rsp = 1'b1;
                     if (enable_ff) begin
                        if (req_pair_type == clfb_pkg::PAIR_DATA) begin
                           // Write at the cursor and advance; drop past the end.
                           if (cursor_ff < size) begin
                              st_wr_en  = 1'b1;
                              cursor_in = cursor_ff + clfb_pkg::CURSOR_W'(1);
                           end
                        end else if (req_pair_type == clfb_pkg::PAIR_CMD) begin
                           if (req_pair_value == clfb_pkg::CMD_CLEAR ||
                               req_pair_value == clfb_pkg::CMD_ENTRY) begin
                              st_clear  = 1'b1;
                              cursor_in = '0;
                           end else if (req_pair_value == clfb_pkg::CMD_HOME ||
                                        req_pair_value == clfb_pkg::CMD_ADDR0) begin
                              cursor_in = '0;
                           end else if (req_pair_value[7]) begin
                              cursor_in = addr_tgt;
                           end
                        end
                     end
                  end
                  clfb_pkg::OP_READ: begin
                     // size never exceeds the store depth.
                     if (req_cell_index < size) begin
                        st_rd_en = 1'b1;
                        state_in = clfb_pkg::ST_READ;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         clfb_pkg::ST_READ: begin
            // Store data arrives; translate it into the result register.
            load_rsp     = 1'b1;
            rsp_char_in  = clfb_pkg::char_map(st_rd_data);
            rsp_range_in = 1'b1;
            state_in     = clfb_pkg::ST_IDLE;
         end
         default: begin
            state_in = clfb_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clfb_pkg::ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_char_ff   <= rsp_char_in;
         rsp_cursor_ff <= cursor_in;
         rsp_range_ff  <= rsp_range_in;
      end
   end

   clfb_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (st_clear),
      .wr_en   (st_wr_en),
      .wr_addr (cursor_ff[IDX_W-1:0]),
      .wr_data (req_pair_value),
      .rd_en   (st_rd_en),
      .rd_addr (req_cell_index[IDX_W-1:0]),
      .rd_data (st_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_in_range   = rsp_range_ff;

endmodule

// ===== hdl/clfb_checker.sv =====
// clfb_props: port-level checks for char_lcd_frame_buffer, bound to the
// top level below. Depends only on the top level's ports.
module clfb_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cell_char,
   input logic [6:0] rsp_cursor_pos,
   input logic       rsp_in_range
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // No new request word while a result is stalled.
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

   // An in-range read always yields a printable code; any other word yields 0.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_range ? (rsp_cell_char >= 8'h20) : (rsp_cell_char == 8'h00)))
      else $error("cell_char inconsistent with in_range");

   // Two lines hold at most 126 cells.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_pos <= 7'd126)
      else $error("cursor past two lines");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind char_lcd_frame_buffer clfb_props u_clfb_props (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_char  (rsp_cell_char),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_in_range   (rsp_in_range)
);
